[hdl/bsa_pkg.sv]
package bsa_pkg;

  localparam int NUM_SLOTS  = 4096;
  localparam int SLOT_WORDS = 4;

  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int WORDS_W    = 14;
  localparam int SLOT_SHIFT = $clog2(SLOT_WORDS);

  // bitmap rows held in the map RAM
  localparam int ROW_W      = 32;
  localparam int ROW_BIT_W  = $clog2(ROW_W);
  localparam int ROWS       = NUM_SLOTS / ROW_W;
  localparam int ROW_IDX_W  = SLOT_W - ROW_BIT_W;

  // remainder unit: one quotient bit a cycle
  localparam int DIV_CNT_W  = $clog2(CNT_W);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = CNT_W;

  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_RESERVE = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] ACTIVE_RESET  = CNT_W'(NUM_SLOTS);
  localparam logic [CNT_W-1:0] RESERVE_RESET = CNT_W'(256);

  typedef enum logic [1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_ALLOC    = 2'd1,
    CMD_ALLOC_NR = 2'd2,
    CMD_MARK     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RESERVE  = 2'd2,
    ST_OVERLAP  = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROVMOD,
    S_DISPATCH,
    S_NEEDMOD,
    S_PROBE,
    S_CHK_RD,
    S_CHK_EV,
    S_CLM_RD,
    S_CLM_WR,
    S_ADV,
    S_SEEK_RD,
    S_SEEK_EV
  } state_e;

endpackage

[hdl/bitmap_slot_allocator.sv]
// Channel   | Handshake          | Word
// ----------+--------------------+------------------------------------------
// command   | start / busy       | command_i, size_words_i, slot_index_i
// result    | done_o (1 cycle)   | status_o, granted_slot_o, avail_slots_o
// config    | cfg_we_i           | cfg_idx_i, cfg_wdata_i
//
// Clear answers in the cycle after it is taken. Other commands run a remainder pass to
// reduce a rover at or past the active count, a dispatch state, a remainder pass to reduce
// an oversize request, then probe and advance states, and a read state, then an evaluate
// state, per 32-slot bitmap row visited by the run check, the claim and the free-slot search.
// Reset empties the map at once through per-row valid flags; no clearing pass.
// The result is shown for exactly one cycle on done_o; the receiver cannot stall.
module bitmap_slot_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        command_i,
  input  logic [bsa_pkg::WORDS_W-1:0]       size_words_i,
  input  logic [bsa_pkg::SLOT_W-1:0]        slot_index_i,
  input  logic                              cfg_we_i,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bsa_pkg::CFG_W-1:0]         cfg_wdata_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [bsa_pkg::SLOT_W-1:0]        granted_slot_o,
  output logic [bsa_pkg::CNT_W-1:0]         avail_slots_o
);

  localparam int SLOT_W     = bsa_pkg::SLOT_W;
  localparam int CNT_W      = bsa_pkg::CNT_W;
  localparam int ROW_W      = bsa_pkg::ROW_W;
  localparam int ROW_BIT_W  = bsa_pkg::ROW_BIT_W;
  localparam int ROW_IDX_W  = bsa_pkg::ROW_IDX_W;
  localparam int DIV_CNT_W  = bsa_pkg::DIV_CNT_W;

  // control state
  bsa_pkg::state_e          state_q, state_d;
  logic                     done_q, done_d;
  logic [SLOT_W-1:0]        rover_q, rover_d;
  logic [CNT_W-1:0]         free_q, free_d;
  logic [CNT_W-1:0]         active_q;
  logic [CNT_W-1:0]         reserve_q;
  logic [bsa_pkg::ROWS-1:0] valid_q;
  logic                     rd_valid_q;

  // working registers
  bsa_pkg::cmd_e            cmd_q, cmd_d;
  logic [CNT_W-1:0]         need_q, need_d;
  logic [SLOT_W-1:0]        slot_q, slot_d;
  logic [SLOT_W-1:0]        needm_q, needm_d;
  logic [SLOT_W-1:0]        pos_q, pos_d;
  logic [SLOT_W-1:0]        endm1_q, endm1_d;
  logic                     phase_b_q, phase_b_d;
  logic [SLOT_W-1:0]        probe_cnt_q, probe_cnt_d;
  logic [CNT_W-1:0]         div_num_q, div_num_d;
  logic [SLOT_W-1:0]        div_rem_q, div_rem_d;
  logic [DIV_CNT_W-1:0]     div_cnt_q, div_cnt_d;
  bsa_pkg::status_e         res_status_q, res_status_d;
  logic [SLOT_W-1:0]        res_granted_q, res_granted_d;
  logic [CNT_W-1:0]         res_free_q, res_free_d;

  // combinational helpers
  logic [bsa_pkg::WORDS_W:0] need_sum;
  logic [CNT_W-1:0]          need_in;
  logic [CNT_W-1:0]          n_cur;
  logic [SLOT_W-1:0]         budget;
  logic                      rover_stale;
  logic [CNT_W-1:0]          div_trial;
  logic [SLOT_W-1:0]         div_rem_nx;
  logic                      div_last;
  logic                      mark_in_range;
  logic                      mark_over;
  logic                      probe_over;
  logic                      reserve_low;
  logic [CNT_W-1:0]          adv_sum;
  logic [SLOT_W-1:0]         adv_rover;
  logic [CNT_W-1:0]          claim_end;
  logic [SLOT_W-1:0]         rover_claim;
  logic [CNT_W-1:0]          free_after;
  logic [SLOT_W-1:0]         probe_next;
  logic                      probe_done;

  logic [ROW_IDX_W-1:0]      row_idx;
  logic [ROW_W-1:0]          row_data;
  logic [ROW_W-1:0]          ram_rdata;
  logic [ROW_W-1:0]          lo_mask;
  logic [ROW_W-1:0]          hi_mask;
  logic [ROW_W-1:0]          row_mask;
  logic                      last_row;
  logic                      hit_bits;
  logic [ROW_W-1:0]          cand;
  logic                      cand_any;
  logic [ROW_BIT_W-1:0]      cand_idx;
  logic [SLOT_W-1:0]         next_pos;

  logic                      ram_we;
  logic                      clear_all;
  logic                      fin;
  bsa_pkg::status_e          fin_status;
  logic [SLOT_W-1:0]         fin_granted;

  // ---------------------------------------------------------------------------
  // arithmetic shared by the states

  assign need_sum = {1'b0, size_words_i} + (bsa_pkg::WORDS_W + 1)'(bsa_pkg::SLOT_WORDS - 1);
  assign need_in  = need_sum[bsa_pkg::SLOT_SHIFT +: CNT_W];

  assign n_cur = (active_q == '0) ? CNT_W'(1) :
                 (active_q > CNT_W'(bsa_pkg::NUM_SLOTS)) ? CNT_W'(bsa_pkg::NUM_SLOTS) :
                 active_q;

  assign budget      = SLOT_W'(n_cur >> 1);
  assign rover_stale = CNT_W'(rover_q) >= n_cur;

  // restoring remainder step against the active count
  assign div_trial  = {div_rem_q, div_num_q[CNT_W-1]};
  assign div_rem_nx = (div_trial >= n_cur) ? SLOT_W'(div_trial - n_cur) : SLOT_W'(div_trial);
  assign div_last   = div_cnt_q == DIV_CNT_W'(CNT_W - 1);

  assign mark_in_range = CNT_W'(slot_q) < n_cur;
  assign mark_over   = ((CNT_W + 1)'(slot_q) + (CNT_W + 1)'(need_q)) > (CNT_W + 1)'(n_cur);
  assign probe_over  = ((CNT_W + 1)'(rover_q) + (CNT_W + 1)'(need_q)) > (CNT_W + 1)'(n_cur);
  assign reserve_low = (CNT_W + 1)'(free_q) < ((CNT_W + 1)'(need_q) + (CNT_W + 1)'(reserve_q));

  assign adv_sum   = CNT_W'(rover_q) + CNT_W'(needm_q);
  assign adv_rover = (adv_sum >= n_cur) ? SLOT_W'(adv_sum - n_cur) : SLOT_W'(adv_sum);

  assign claim_end   = CNT_W'(endm1_q) + CNT_W'(1);
  assign rover_claim = (claim_end >= n_cur) ? '0 : SLOT_W'(claim_end);
  assign free_after  = (free_q >= need_q) ? (free_q - need_q) : '0;

  assign probe_next = probe_cnt_q + SLOT_W'(1);
  assign probe_done = probe_next == budget;

  // ---------------------------------------------------------------------------
  // bitmap row window [pos_q, endm1_q]

  assign row_idx  = pos_q[SLOT_W-1:ROW_BIT_W];
  assign row_data = rd_valid_q ? ram_rdata : '0;
  assign last_row = endm1_q[SLOT_W-1:ROW_BIT_W] == row_idx;
  assign lo_mask  = {ROW_W{1'b1}} << pos_q[ROW_BIT_W-1:0];
  assign hi_mask  = last_row ?
                    ({ROW_W{1'b1}} >> (ROW_BIT_W'(ROW_W - 1) - endm1_q[ROW_BIT_W-1:0])) :
                    {ROW_W{1'b1}};
  assign row_mask = lo_mask & hi_mask;
  assign hit_bits = |(row_data & row_mask);
  assign cand     = ~row_data & row_mask;
  assign cand_any = |cand;
  assign next_pos = {ROW_IDX_W'(row_idx + ROW_IDX_W'(1)), {ROW_BIT_W{1'b0}}};

  always_comb begin
    cand_idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        cand_idx = ROW_BIT_W'(i);
      end
    end
  end

  bsa_ram #(
    .WIDTH(ROW_W),
    .DEPTH(bsa_pkg::ROWS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(row_idx),
    .wdata_i(row_data | row_mask),
    .raddr_i(row_idx),
    .rdata_o(ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // next state

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsa_pkg::S_IDLE: begin
        if (start) begin
          if (bsa_pkg::cmd_e'(command_i) == bsa_pkg::CMD_CLEAR) begin
            state_d = bsa_pkg::S_IDLE;
          end else if (rover_stale) begin
            state_d = bsa_pkg::S_ROVMOD;
          end else begin
            state_d = bsa_pkg::S_DISPATCH;
          end
        end
      end
      bsa_pkg::S_ROVMOD: begin
        if (div_last) begin
          state_d = bsa_pkg::S_DISPATCH;
        end
      end
      bsa_pkg::S_DISPATCH: begin
        if (cmd_q == bsa_pkg::CMD_MARK) begin
          if (mark_in_range && !mark_over && need_q != '0) begin
            state_d = bsa_pkg::S_CHK_RD;
          end else begin
            state_d = bsa_pkg::S_IDLE;
          end
        end else if (cmd_q == bsa_pkg::CMD_ALLOC && reserve_low) begin
          state_d = bsa_pkg::S_IDLE;
        end else if (budget == '0) begin
          state_d = bsa_pkg::S_IDLE;
        end else if (need_q >= n_cur) begin
          state_d = bsa_pkg::S_NEEDMOD;
        end else begin
          state_d = bsa_pkg::S_PROBE;
        end
      end
      bsa_pkg::S_NEEDMOD: begin
        if (div_last) begin
          state_d = bsa_pkg::S_PROBE;
        end
      end
      bsa_pkg::S_PROBE: begin
        if (probe_over) begin
          state_d = bsa_pkg::S_ADV;
        end else if (need_q == '0) begin
          state_d = bsa_pkg::S_IDLE;
        end else begin
          state_d = bsa_pkg::S_CHK_RD;
        end
      end
      bsa_pkg::S_CHK_RD: state_d = bsa_pkg::S_CHK_EV;
      bsa_pkg::S_CHK_EV: begin
        if (hit_bits) begin
          state_d = (cmd_q == bsa_pkg::CMD_MARK) ? bsa_pkg::S_IDLE : bsa_pkg::S_ADV;
        end else if (last_row) begin
          state_d = bsa_pkg::S_CLM_RD;
        end else begin
          state_d = bsa_pkg::S_CHK_RD;
        end
      end
      bsa_pkg::S_CLM_RD: state_d = bsa_pkg::S_CLM_WR;
      bsa_pkg::S_CLM_WR: begin
        state_d = last_row ? bsa_pkg::S_IDLE : bsa_pkg::S_CLM_RD;
      end
      bsa_pkg::S_ADV:     state_d = bsa_pkg::S_SEEK_RD;
      bsa_pkg::S_SEEK_RD: state_d = bsa_pkg::S_SEEK_EV;
      bsa_pkg::S_SEEK_EV: begin
        if (cand_any) begin
          state_d = probe_done ? bsa_pkg::S_IDLE : bsa_pkg::S_PROBE;
        end else if (last_row) begin
          state_d = (!phase_b_q && rover_q != '0) ? bsa_pkg::S_SEEK_RD : bsa_pkg::S_IDLE;
        end else begin
          state_d = bsa_pkg::S_SEEK_RD;
        end
      end
      default: state_d = bsa_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath and outputs

  always_comb begin
    rover_d       = rover_q;
    free_d        = free_q;
    cmd_d         = cmd_q;
    need_d        = need_q;
    slot_d        = slot_q;
    needm_d       = needm_q;
    pos_d         = pos_q;
    endm1_d       = endm1_q;
    phase_b_d     = phase_b_q;
    probe_cnt_d   = probe_cnt_q;
    div_num_d     = div_num_q;
    div_rem_d     = div_rem_q;
    div_cnt_d     = div_cnt_q;
    res_status_d  = res_status_q;
    res_granted_d = res_granted_q;
    res_free_d    = res_free_q;
    done_d        = 1'b0;
    ram_we        = 1'b0;
    clear_all     = 1'b0;
    fin           = 1'b0;
    fin_status    = bsa_pkg::ST_OK;
    fin_granted   = '0;

    unique case (state_q)
      bsa_pkg::S_IDLE: begin
        if (start) begin
          cmd_d     = bsa_pkg::cmd_e'(command_i);
          need_d    = need_in;
          slot_d    = slot_index_i;
          div_num_d = CNT_W'(rover_q);
          div_rem_d = '0;
          div_cnt_d = '0;
          if (bsa_pkg::cmd_e'(command_i) == bsa_pkg::CMD_CLEAR) begin
            clear_all = 1'b1;
            free_d    = n_cur;
            rover_d   = '0;
            fin       = 1'b1;
          end
        end
      end
      bsa_pkg::S_ROVMOD, bsa_pkg::S_NEEDMOD: begin
        div_num_d = div_num_q << 1;
        div_rem_d = div_rem_nx;
        div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
        if (div_last) begin
          if (state_q == bsa_pkg::S_ROVMOD) begin
            rover_d = div_rem_nx;
          end else begin
            needm_d = div_rem_nx;
          end
        end
      end
      bsa_pkg::S_DISPATCH: begin
        probe_cnt_d = '0;
        needm_d     = SLOT_W'(need_q);
        div_num_d   = need_q;
        div_rem_d   = '0;
        div_cnt_d   = '0;
        pos_d       = slot_q;
        endm1_d     = SLOT_W'(CNT_W'(slot_q) + need_q - CNT_W'(1));
        if (cmd_q == bsa_pkg::CMD_MARK) begin
          if (mark_in_range) begin
            rover_d = slot_q;
            if (mark_over) begin
              fin        = 1'b1;
              fin_status = bsa_pkg::ST_OVERLAP;
            end else if (need_q == '0) begin
              fin         = 1'b1;
              fin_granted = slot_q;
            end
          end else begin
            fin        = 1'b1;
            fin_status = bsa_pkg::ST_OVERLAP;
          end
        end else if (cmd_q == bsa_pkg::CMD_ALLOC && reserve_low) begin
          fin        = 1'b1;
          fin_status = bsa_pkg::ST_RESERVE;
        end else if (budget == '0) begin
          fin        = 1'b1;
          fin_status = bsa_pkg::ST_NO_SPACE;
        end
      end
      bsa_pkg::S_PROBE: begin
        pos_d   = rover_q;
        endm1_d = SLOT_W'(CNT_W'(rover_q) + need_q - CNT_W'(1));
        if (!probe_over && need_q == '0) begin
          fin         = 1'b1;
          fin_granted = rover_q;
        end
      end
      bsa_pkg::S_CHK_EV: begin
        if (hit_bits) begin
          if (cmd_q == bsa_pkg::CMD_MARK) begin
            fin        = 1'b1;
            fin_status = bsa_pkg::ST_OVERLAP;
          end
        end else if (last_row) begin
          // run is free: rewind to its first row to claim it
          pos_d = rover_q;
        end else begin
          pos_d = next_pos;
        end
      end
      bsa_pkg::S_CLM_WR: begin
        ram_we = 1'b1;
        if (last_row) begin
          free_d      = free_after;
          rover_d     = rover_claim;
          fin         = 1'b1;
          fin_granted = rover_q;
        end else begin
          pos_d = next_pos;
        end
      end
      bsa_pkg::S_ADV: begin
        rover_d   = adv_rover;
        pos_d     = adv_rover;
        endm1_d   = SLOT_W'(n_cur - CNT_W'(1));
        phase_b_d = 1'b0;
      end
      bsa_pkg::S_SEEK_EV: begin
        if (cand_any) begin
          rover_d     = {row_idx, cand_idx};
          probe_cnt_d = probe_next;
          if (probe_done) begin
            fin        = 1'b1;
            fin_status = bsa_pkg::ST_NO_SPACE;
          end
        end else if (last_row) begin
          if (!phase_b_q && rover_q != '0) begin
            // wrap: search the slots below the rover
            phase_b_d = 1'b1;
            pos_d     = '0;
            endm1_d   = rover_q - SLOT_W'(1);
          end else begin
            fin        = 1'b1;
            fin_status = bsa_pkg::ST_NO_SPACE;
          end
        end else begin
          pos_d = next_pos;
        end
      end
      default: begin
      end
    endcase

    if (fin) begin
      done_d        = 1'b1;
      res_status_d  = fin_status;
      res_granted_d = fin_granted;
      res_free_d    = free_d;
    end
  end

  // ---------------------------------------------------------------------------
  // registers

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bsa_pkg::S_IDLE;
      done_q     <= 1'b0;
      rover_q    <= '0;
      free_q     <= bsa_pkg::ACTIVE_RESET;
      active_q   <= bsa_pkg::ACTIVE_RESET;
      reserve_q  <= bsa_pkg::RESERVE_RESET;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      done_q     <= done_d;
      rover_q    <= rover_d;
      free_q     <= free_d;
      rd_valid_q <= valid_q[row_idx];
      if (clear_all) begin
        valid_q <= '0;
      end else if (ram_we) begin
        valid_q[row_idx] <= 1'b1;
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == bsa_pkg::REG_ACTIVE) begin
          active_q <= cfg_wdata_i;
        end else begin
          reserve_q <= cfg_wdata_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q         <= cmd_d;
    need_q        <= need_d;
    slot_q        <= slot_d;
    needm_q       <= needm_d;
    pos_q         <= pos_d;
    endm1_q       <= endm1_d;
    phase_b_q     <= phase_b_d;
    probe_cnt_q   <= probe_cnt_d;
    div_num_q     <= div_num_d;
    div_rem_q     <= div_rem_d;
    div_cnt_q     <= div_cnt_d;
    res_status_q  <= res_status_d;
    res_granted_q <= res_granted_d;
    res_free_q    <= res_free_d;
  end

  assign busy           = state_q != bsa_pkg::S_IDLE;
  assign done_o         = done_q;
  assign status_o       = res_status_q;
  assign granted_slot_o = res_granted_q;
  assign avail_slots_o  = res_free_q;

`ifndef ASSERT_OFF
  a_rover_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsa_pkg::S_PROBE) |-> (CNT_W'(rover_q) < n_cur))
    else $error("rover outside the active slots at a probe");

  a_probe_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsa_pkg::S_PROBE) |-> (probe_cnt_q < budget))
    else $error("probe issued past the probe budget");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i == bsa_pkg::CMD_CLEAR)
      |=> (done_o && status_o == bsa_pkg::ST_OK && avail_slots_o == n_cur))
    else $error("clear did not report a full free count");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != bsa_pkg::ST_OK) |-> (granted_slot_o == '0))
    else $error("failed command reports a granted slot");

  a_write_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (row_mask != '0 && $past(state_q) == bsa_pkg::S_CLM_RD))
    else $error("map write outside a claim step");
`endif

endmodule

[hdl/bsa_ram.sv]
module bsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
